### design/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types, constants and calendar helpers for the epoch-to-date block.
// ----------------------------------------------------------------------------
package ecd_pkg;

    localparam int unsigned PADDR_W = 3;

    // Division by constants through reciprocal multiplication. Each reciprocal
    // is rounded up and is exact for every dividend the datapath can present.
    localparam logic [26:0] RECIP_675 = 27'd101806633;  // ceil(2^36 / 675)
    localparam logic [9:0]  DAY_LO    = 10'd675;        // 86400 / 128
    localparam logic [15:0] RECIP_15  = 16'd34953;      // ceil(2^19 / 15)
    localparam logic [16:0] RECIP_7   = 17'd74899;      // ceil(2^19 / 7)

    localparam logic signed [17:0] SECS_PER_HOUR = 18'sd3600;

    localparam logic [11:0] BASE_YEAR      = 12'd1970;
    localparam logic [1:0]  BASE_Y4        = 2'd2;     // 1970 mod 4
    localparam logic [6:0]  BASE_Y100      = 7'd70;    // 1970 mod 100
    localparam logic [8:0]  BASE_Y400      = 9'd370;   // 1970 mod 400
    localparam logic [6:0]  Y100_LAST      = 7'd99;
    localparam logic [8:0]  Y400_LAST      = 9'd399;
    localparam logic [8:0]  DAYS_COMMON    = 9'd365;
    localparam logic [8:0]  DAYS_LEAP      = 9'd366;
    localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;
    localparam logic [3:0]  EPOCH_WEEKDAY  = 4'd3;     // 1970-01-01 was a Thursday
    localparam logic [3:0]  WEEK_DAYS      = 4'd7;

    localparam logic [PADDR_W-1:0] ADDR_ZONE_OFFSET = 3'd0;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DAY_QUO,
        OP_DAY_REM,
        OP_MIN_QUO,
        OP_MIN_REM,
        OP_HOUR_REM,
        OP_YEAR_STEP,
        OP_MONTH_STEP,
        OP_FINISH
    } ecd_op_t;

    typedef struct packed {
        ecd_op_t op;
    } ecd_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } ecd_stat_t;

    // Days before the start of month m (0..12), leap years one more from March.
    function automatic logic [8:0] month_begin(input logic [3:0] m, input logic leap);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            4'd12:   v = 9'd365;
            default: v = 9'd0;
        endcase
        if (leap && (m >= 4'd2)) begin
            v = v + 9'd1;
        end
        return v;
    endfunction

endpackage

### design/epoch_seconds_to_calendar_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date
// Converts seconds since 1970-01-01 UTC to local calendar date and time.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive epoch_seconds and raise start; it is taken at a rising
//   edge where start is high and busy is low. busy stays high while the item
//   is worked on.
//   Result beat: done is high for exactly one cycle with all result ports
//   valid; the receiver must take it in that cycle.
//   It works in five split steps that divide by constants through reciprocal
//   multiplication, then the year walk, one year per cycle, and the month
//   walk, one month per cycle. One item is in flight at a time; busy is
//   already low in the done cycle, so the next item may be taken there.
//   zone_offset_hours (APB, byte address 0) holds signed whole hours added
//   before conversion; write it only while busy is low. A shifted time below
//   zero gives the epoch with clamped set.
//   Reset clears the sequencer and sets the zone offset to +1 hour.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ecd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [31:0]                 epoch_seconds,
    output logic                        done,
    output logic [5:0]                  second_of_minute,
    output logic [5:0]                  minute_of_hour,
    output logic [4:0]                  hour_of_day,
    output logic [2:0]                  day_of_week,
    output logic [4:0]                  day_of_month,
    output logic [3:0]                  month_of_year,
    output logic [11:0]                 year_number,
    output logic                        clamped
);
    import ecd_pkg::*;

    logic [4:0] zone_reg;
    logic       zone_hit;
    ecd_cmd_t   cmd;
    ecd_stat_t  stat;

    // Only the word select bit decodes; byte offsets within the word alias.
    assign zone_hit = (paddr[PADDR_W-1] == ADDR_ZONE_OFFSET[PADDR_W-1]);
    assign pready   = 1'b1;
    assign prdata   = zone_hit ? {27'd0, zone_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= 5'd1;
        end
        else if (psel && penable && pwrite && zone_hit)
        begin
            zone_reg <= pwdata[4:0];
        end
    end

    ecd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    ecd_dp u_dp (
        .clk               (clk),
        .cmd               (cmd),
        .stat              (stat),
        .epoch_seconds     (epoch_seconds),
        .zone_offset_hours (zone_reg),
        .second_of_minute  (second_of_minute),
        .minute_of_hour    (minute_of_hour),
        .hour_of_day       (hour_of_day),
        .day_of_week       (day_of_week),
        .day_of_month      (day_of_month),
        .month_of_year     (month_of_year),
        .year_number       (year_number),
        .clamped           (clamped)
    );

endmodule

### design/ecd_dp.sv
// ----------------------------------------------------------------------------
// ecd_dp
// Datapath: zone shift and clamp, reciprocal-multiply splits into days,
// seconds, minutes and hours, the weekday, the year walk and the month walk.
// ----------------------------------------------------------------------------
module ecd_dp (
    input  logic               clk,
    input  ecd_pkg::ecd_cmd_t  cmd,
    output ecd_pkg::ecd_stat_t stat,
    input  logic [31:0]        epoch_seconds,
    input  logic [4:0]         zone_offset_hours,
    output logic [5:0]         second_of_minute,
    output logic [5:0]         minute_of_hour,
    output logic [4:0]         hour_of_day,
    output logic [2:0]         day_of_week,
    output logic [4:0]         day_of_month,
    output logic [3:0]         month_of_year,
    output logic [11:0]        year_number,
    output logic               clamped
);
    import ecd_pkg::*;

    logic [32:0] secs_reg, secs_next;
    logic [15:0] days_reg, days_next;
    logic [12:0] wq_reg, wq_next;
    logic [16:0] sod_reg, sod_next;
    logic [10:0] mod_reg, mod_next;
    logic [11:0] year_reg, year_next;
    logic [1:0]  y4_reg, y4_next;
    logic [6:0]  y100_reg, y100_next;
    logic [8:0]  y400_reg, y400_next;
    logic [3:0]  mon_reg, mon_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [2:0]  dow_reg, dow_next;
    logic [4:0]  mday_reg, mday_next;
    logic [3:0]  month_reg, month_next;
    logic        clamp_reg, clamp_next;

    logic [52:0]        day_prod;
    logic [25:0]        day_sub;
    logic [32:0]        wk_prod;
    logic [15:0]        wk_sub;
    logic [14:0]        mul15_in;
    logic [30:0]        mul15_prod;
    logic [14:0]        sod_sub;
    logic [8:0]         mod_sub;
    logic [3:0]         dow_in;
    logic signed [17:0] zone_ext, shift_secs;
    logic signed [33:0] shifted;
    logic               leap;
    logic [8:0]         year_len, mb_next, mb_cur;
    logic [15:0]        mday_full;

    always_comb
    begin
        // 86400 is 128 * 675, so the low seven bits pass straight through.
        day_prod = 53'(secs_reg[32:7]) * 53'(RECIP_675);
        day_sub  = secs_reg[32:7] - ({10'd0, days_reg} * {16'd0, DAY_LO});
        wk_prod  = {17'd0, days_reg} * {16'd0, RECIP_7};
        wk_sub   = days_reg - ({wq_reg, 3'b000} - {3'b000, wq_reg});
        dow_in   = {1'b0, wk_sub[2:0]} + EPOCH_WEEKDAY;

        // Division by 60 is a shift by two and a division by 15.
        mul15_in   = (cmd.op == OP_MIN_QUO) ? sod_reg[16:2] : {6'd0, mod_reg[10:2]};
        mul15_prod = {16'd0, mul15_in} * {15'd0, RECIP_15};
        sod_sub    = sod_reg[16:2] - ({mod_reg, 4'b0000} - {4'b0000, mod_reg});
        mod_sub    = mod_reg[10:2] - ({hour_reg, 4'b0000} - {4'b0000, hour_reg});

        zone_ext   = {{13{zone_offset_hours[4]}}, zone_offset_hours};
        shift_secs = zone_ext * SECS_PER_HOUR;
        shifted    = $signed({2'b00, epoch_seconds}) + {{16{shift_secs[17]}}, shift_secs};

        leap      = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
        year_len  = leap ? DAYS_LEAP : DAYS_COMMON;
        mb_next   = month_begin(mon_reg + 4'd1, leap);
        mb_cur    = month_begin(mon_reg, leap);
        mday_full = days_reg - {7'd0, mb_cur} + 16'd1;

        stat.year_done  = (days_reg < {7'd0, year_len});
        stat.month_done = (mon_reg == LAST_MONTH_IDX) || (days_reg < {7'd0, mb_next});

        secs_next  = secs_reg;
        days_next  = days_reg;
        wq_next    = wq_reg;
        sod_next   = sod_reg;
        mod_next   = mod_reg;
        year_next  = year_reg;
        y4_next    = y4_reg;
        y100_next  = y100_reg;
        y400_next  = y400_reg;
        mon_next   = mon_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        dow_next   = dow_reg;
        mday_next  = mday_reg;
        month_next = month_reg;
        clamp_next = clamp_reg;

        case (cmd.op)
            OP_LOAD:
            begin
                clamp_next = shifted[33];
                secs_next  = shifted[33] ? 33'd0 : shifted[32:0];
            end
            OP_DAY_QUO:
            begin
                days_next = day_prod[51:36];
            end
            OP_DAY_REM:
            begin
                sod_next = {day_sub[9:0], secs_reg[6:0]};
                wq_next  = wk_prod[31:19];
            end
            OP_MIN_QUO:
            begin
                mod_next = mul15_prod[29:19];
                dow_next = (dow_in >= WEEK_DAYS) ? 3'(dow_in - WEEK_DAYS) : dow_in[2:0];
            end
            OP_MIN_REM:
            begin
                sec_next  = {sod_sub[3:0], sod_reg[1:0]};
                hour_next = mul15_prod[23:19];
            end
            OP_HOUR_REM:
            begin
                min_next  = {mod_sub[3:0], mod_reg[1:0]};
                year_next = BASE_YEAR;
                y4_next   = BASE_Y4;
                y100_next = BASE_Y100;
                y400_next = BASE_Y400;
                mon_next  = 4'd0;
            end
            OP_YEAR_STEP:
            begin
                days_next = days_reg - {7'd0, year_len};
                year_next = year_reg + 12'd1;
                y4_next   = y4_reg + 2'd1;
                y100_next = (y100_reg == Y100_LAST) ? 7'd0 : y100_reg + 7'd1;
                y400_next = (y400_reg == Y400_LAST) ? 9'd0 : y400_reg + 9'd1;
            end
            OP_MONTH_STEP:
            begin
                mon_next = mon_reg + 4'd1;
            end
            OP_FINISH:
            begin
                mday_next  = mday_full[4:0];
                month_next = mon_reg + 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        secs_reg  <= secs_next;
        days_reg  <= days_next;
        wq_reg    <= wq_next;
        sod_reg   <= sod_next;
        mod_reg   <= mod_next;
        year_reg  <= year_next;
        y4_reg    <= y4_next;
        y100_reg  <= y100_next;
        y400_reg  <= y400_next;
        mon_reg   <= mon_next;
        sec_reg   <= sec_next;
        min_reg   <= min_next;
        hour_reg  <= hour_next;
        dow_reg   <= dow_next;
        mday_reg  <= mday_next;
        month_reg <= month_next;
        clamp_reg <= clamp_next;
    end

    assign second_of_minute = sec_reg;
    assign minute_of_hour   = min_reg;
    assign hour_of_day      = hour_reg;
    assign day_of_week      = dow_reg;
    assign day_of_month     = mday_reg;
    assign month_of_year    = month_reg;
    assign year_number      = year_reg;
    assign clamped          = clamp_reg;

endmodule

### design/ecd_ctrl.sv
// ----------------------------------------------------------------------------
// ecd_ctrl
// Sequencer: walks the datapath through the split steps, the year walk and
// the month walk, and raises done for one cycle at the end.
// ----------------------------------------------------------------------------
module ecd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output ecd_pkg::ecd_cmd_t  cmd,
    input  ecd_pkg::ecd_stat_t stat
);
    import ecd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY_QUO,
        S_DAY_REM,
        S_MIN_QUO,
        S_MIN_REM,
        S_HOUR_REM,
        S_YEAR,
        S_MONTH
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.op     = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DAY_QUO;
                end
            end
            S_DAY_QUO:
            begin
                cmd.op     = OP_DAY_QUO;
                state_next = S_DAY_REM;
            end
            S_DAY_REM:
            begin
                cmd.op     = OP_DAY_REM;
                state_next = S_MIN_QUO;
            end
            S_MIN_QUO:
            begin
                cmd.op     = OP_MIN_QUO;
                state_next = S_MIN_REM;
            end
            S_MIN_REM:
            begin
                cmd.op     = OP_MIN_REM;
                state_next = S_HOUR_REM;
            end
            S_HOUR_REM:
            begin
                cmd.op     = OP_HOUR_REM;
                state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (stat.year_done)
                begin
                    state_next = S_MONTH;
                end
                else
                begin
                    cmd.op = OP_YEAR_STEP;
                end
            end
            S_MONTH:
            begin
                if (stat.month_done)
                begin
                    cmd.op     = OP_FINISH;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = OP_MONTH_STEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### design/ecd_chk.sv
// ----------------------------------------------------------------------------
// ecd_chk
// Port-level checks on the epoch-to-date block, bound to the top level.
// ----------------------------------------------------------------------------
module ecd_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [5:0]  second_of_minute,
    input logic [5:0]  minute_of_hour,
    input logic [4:0]  hour_of_day,
    input logic [4:0]  day_of_month,
    input logic [3:0]  month_of_year,
    input logic [11:0] year_number,
    input logic        clamped
);

    // An accepted beat makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // The block goes idle exactly with its result beat.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result beat while busy or without prior work");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (second_of_minute < 6'd60 && minute_of_hour < 6'd60 && hour_of_day < 5'd24))
        else $error("time of day out of range");

    a_clamp_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clamped) |-> (year_number == 12'd1970 && month_of_year == 4'd1
                               && day_of_month == 5'd1 && hour_of_day == 5'd0))
        else $error("clamped result is not the epoch");

endmodule

bind epoch_seconds_to_calendar_date ecd_chk u_ecd_chk (.*);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for epoch_seconds_to_calendar_date. An independent calendar
// predictor works out the expected local date and time for every accepted
// input beat and checks it against each result beat. The run steps the zone
// offset register through its extremes and several other settings. Directed
// timestamps cover the leap-year and clamping corners, and random timestamps
// follow them under several sender idling patterns.
// ----------------------------------------------------------------------------
module tb;

    import ecd_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;
    localparam int unsigned SECS_IN_DAY    = 86400;
    localparam int unsigned DRAIN_CYCLES   = 220;

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [2:0]  wday;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [11:0] year;
        logic        clamp;
    } calendar_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               start = 1'b0;
    logic               busy;
    logic [31:0]        epoch_seconds = '0;
    logic               done;
    logic [5:0]         second_of_minute;
    logic [5:0]         minute_of_hour;
    logic [4:0]         hour_of_day;
    logic [2:0]         day_of_week;
    logic [4:0]         day_of_month;
    logic [3:0]         month_of_year;
    logic [11:0]        year_number;
    logic               clamped;

    logic [31:0] pending_seconds [$];
    calendar_t   expected_dates [$];
    logic [4:0]  zone_model = 5'd1;
    logic        beat_taken = 1'b0;
    int unsigned sender_idle_pct = 0;
    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned zones_used = 0;
    int unsigned clamped_seen = 0;
    int unsigned leap_days_seen = 0;

    epoch_seconds_to_calendar_date u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_week      (day_of_week),
        .day_of_month     (day_of_month),
        .month_of_year    (month_of_year),
        .year_number      (year_number),
        .clamped          (clamped)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mon, input bit leap);
        case (mon)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic longint year_start(input int unsigned yr);
        longint days;
        days = 0;
        for (int unsigned y = 1970; y < yr; y++)
        begin
            days += leap_year(y) ? 366 : 365;
        end
        return days * SECS_IN_DAY;
    endfunction

    function automatic calendar_t convert_to_local(input logic [31:0] utc,
                                                   input logic [4:0] zone);
        calendar_t   r;
        longint      local_s;
        longint      days;
        int unsigned yr;
        int unsigned mon;
        bit          leap;
        r = '0;
        local_s = {32'd0, utc};
        local_s = local_s + 3600 * longint'($signed(zone));
        if (local_s < 0)
        begin
            local_s = 0;
            r.clamp = 1'b1;
        end
        r.sec  = 6'(local_s % 60);
        r.min  = 6'((local_s / 60) % 60);
        r.hour = 5'((local_s / 3600) % 24);
        days   = local_s / SECS_IN_DAY;
        // The epoch fell on a Thursday, which is 3 with Monday as 0.
        r.wday = 3'((days + 3) % 7);
        yr = 1970;
        while (days >= (leap_year(yr) ? 366 : 365))
        begin
            days -= leap_year(yr) ? 366 : 365;
            yr++;
        end
        leap = leap_year(yr);
        mon = 1;
        while (days >= days_in_month(mon, leap))
        begin
            days -= days_in_month(mon, leap);
            mon++;
        end
        r.mday  = 5'(days + 1);
        r.month = 4'(mon);
        r.year  = 12'(yr);
        return r;
    endfunction

    function automatic string fmt_date(input calendar_t d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wday %0d clamp %0d", d.year, d.month,
                         d.mday, d.hour, d.min, d.sec, d.wday, d.clamp);
    endfunction

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // Timestamps near local day, year or March boundaries, near either end of the
    // range or at random; boundary times undo the zone shift to land in local time.
    function automatic logic [31:0] pick_timestamp(input int hrs);
        int unsigned sel;
        int unsigned yr;
        longint      t;
        sel = $urandom_range(9);
        yr  = $urandom_range(2105, 1970);
        case (sel)
            4:       t = longint'($urandom_range(49710)) * SECS_IN_DAY;
            5:       t = year_start(yr);
            6:       t = year_start(yr) + (59 + int'(leap_year(yr))) * SECS_IN_DAY;
            7:       t = $urandom_range(100000);
            8:       t = 64'hFFFF_FFFF - longint'($urandom_range(200000));
            default: t = $urandom();
        endcase
        if (sel >= 4 && sel <= 6)
        begin
            t = t - longint'(hrs) * 3600 + longint'($urandom_range(4)) - 2;
        end
        return t[31:0];
    endfunction

    // Input driver: a new beat is offered once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || beat_taken))
        begin
            if (pending_seconds.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                epoch_seconds <= pending_seconds.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        calendar_t seen;
        calendar_t want;
        if (!rst_n)
        begin
            zone_model <= 5'd1;
            beat_taken <= 1'b0;
        end
        else
        begin
            seen = {second_of_minute, minute_of_hour, hour_of_day, day_of_week,
                    day_of_month, month_of_year, year_number, clamped};
            // The result beat is checked before a new input beat is predicted,
            // since both can fall on the same edge.
            if (done)
            begin
                if (expected_dates.size() == 0)
                begin
                    log_failure({"unexpected result beat: ", fmt_date(seen)});
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (seen !== want)
                    begin
                        log_failure({"date mismatch: expected ", fmt_date(want),
                                     ", got ", fmt_date(seen)});
                    end
                    if (want.clamp)
                    begin
                        clamped_seen++;
                    end
                    if (want.month == 4'd2 && want.mday == 5'd29)
                    begin
                        leap_days_seen++;
                    end
                end
            end
            beat_taken <= start && !busy;
            if (start && !busy)
            begin
                expected_dates.push_back(convert_to_local(epoch_seconds, zone_model));
                accepted_count++;
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_ZONE_OFFSET)
            begin
                zone_model <= pwdata[4:0];
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_zone(input logic [4:0] want);
        logic [31:0] back;
        apb_access(1'b0, ADDR_ZONE_OFFSET, 32'd0, back);
        if (back[4:0] !== want)
        begin
            log_failure($sformatf("zone readback: expected %0d, got %0d",
                                  $signed(want), $signed(back[4:0])));
        end
    endtask

    // Upper data bits are random; only the low five belong to the register.
    task automatic write_zone(input int hrs);
        logic [31:0] data;
        logic [31:0] back;
        data = $urandom();
        data[4:0] = hrs[4:0];
        apb_access(1'b1, ADDR_ZONE_OFFSET, data, back);
        check_zone(data[4:0]);
        zones_used++;
    endtask

    task automatic queue_item(input logic [31:0] secs);
        pending_seconds.push_back(secs);
        queued_count++;
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] back;
        int          hrs;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset offset of +1 hour.
        check_zone(5'd1);
        zones_used++;
        queue_item(32'd0);
        queue_item(32'hFFFF_FFFF);
        queue_item(32'd82799);          // 23:59:59 local on the first day
        wait_idle();
        // A write to an address with no register must leave the offset alone.
        apb_access(1'b1, ADDR_UNUSED, 32'hFFFF_FFFF, back);
        check_zone(5'd1);
        queue_item(32'd7200);
        wait_idle();

        write_zone(0);
        queue_item(32'd31535999);       // last second of 1970
        queue_item(32'd31536000);
        queue_item(32'd68169600);       // 1972-02-29
        queue_item(32'd951782400);      // 2000-02-29, leap by the 400 rule
        queue_item(32'd978220800);      // 2000-12-31, day 366
        queue_item(32'd4107542399);     // 2100-02-28 23:59:59, not a leap year
        queue_item(32'd4107542400);     // 2100-03-01
        queue_item(32'd2147483647);
        queue_item(32'd2147483648);
        queue_item(32'hFFFF_FFFF);
        wait_idle();

        write_zone(-12);
        queue_item(32'd0);
        queue_item(32'd43199);          // one second short of the epoch
        queue_item(32'd43200);          // exactly the epoch, not clamped
        queue_item(32'hFFFF_FFFF);
        wait_idle();

        write_zone(14);
        queue_item(32'hFFFF_FFFF);
        queue_item(32'd0);
        wait_idle();

        // Raw register extremes, outside the nominal range.
        write_zone(15);
        queue_item(32'hFFFF_FFFF);
        wait_idle();
        write_zone(-16);
        queue_item(32'd57599);
        queue_item(32'd57600);
        queue_item(32'd0);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       hrs = 0;
                1:       hrs = -12;
                2:       hrs = 14;
                3:       hrs = -16;
                4:       hrs = 15;
                default: hrs = int'($urandom_range(31)) - 16;
            endcase
            write_zone(hrs);
            case (p % 3)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 67;
                default: sender_idle_pct = 19;
            endcase
            for (int i = 0; i < 125; i++)
            begin
                // Halfway through one phase the sender holds off until the
                // block has drained completely.
                if (p == 4 && i == 62)
                begin
                    wait_idle();
                end
                queue_item(pick_timestamp(hrs));
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Converted %0d timestamps under %0d zone offset settings.",
                 accepted_count, zones_used);
        $display("Of these, %0d clamped to the epoch and %0d landed on February 29.",
                 clamped_seen, leap_days_seen);
        if (mismatch_count == 0 && expected_dates.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results outstanding", mismatch_count,
                     expected_dates.size());
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #12000000;
        $display("Timeout with %0d of %0d beats accepted", accepted_count, queued_count);
        $display("Some tests failed");
        $finish;
    end

endmodule
